// ===== rtl/b64u_pkg.sv =====
// package: character classes, decoder state and per-character group step
package b64u_pkg;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [5:0] val;
    } t_chr;

    typedef struct packed {
        logic [5:0] sx0;
        logic [5:0] sx1;
        logic [5:0] sx2;
        logic [1:0] pos;
        logic [1:0] pad;
        logic       third;
    } t_state;

    typedef struct packed {
        t_state     st;
        logic       ok;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_feed;

    typedef struct packed {
        logic [1:0] cnt;
        logic       bad;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_res;

    localparam logic [7:0] CH_PAD   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic t_chr classify(input logic [7:0] ch);
        t_chr r;
        r.cls = CLS_BAD;
        r.val = 6'd0;
        if (ch == CH_PAD) begin
            r.cls = CLS_PAD;
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            r.cls = CLS_DATA;
            r.val = 6'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            r.cls = CLS_DATA;
            r.val = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            r.cls = CLS_DATA;
            r.val = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == CH_DASH) begin
            r.cls = CLS_DATA;
            r.val = 6'd62;
        end else if (ch == CH_UNDER) begin
            r.cls = CLS_DATA;
            r.val = 6'd63;
        end
        return r;
    endfunction

    // one character into the group; bytes come out when the group closes
    function automatic t_feed feed(input t_state s, input t_cls cls, input logic [5:0] val);
        t_feed      r;
        logic [1:0] pc;
        logic [5:0] c4;
        r     = '0;
        r.st  = s;
        r.ok  = 1'b1;
        pc    = s.pad;
        c4    = (cls == CLS_PAD) ? 6'd0 : val;
        if (cls == CLS_BAD) begin
            r.ok = 1'b0;
        end else begin
            case (s.pos)
                2'd0: begin
                    if (cls == CLS_PAD) begin
                        r.ok = 1'b0;
                    end else begin
                        r.st.sx0 = val;
                        r.st.pos = 2'd1;
                    end
                end
                2'd1: begin
                    if (cls == CLS_PAD) begin
                        r.ok = 1'b0;
                    end else begin
                        r.st.sx1 = val;
                        r.st.pos = 2'd2;
                    end
                end
                2'd2: begin
                    if (cls == CLS_PAD) begin
                        if (s.pad >= 2'd2) begin
                            r.ok = 1'b0;
                        end
                        r.st.third = 1'b1;
                        r.st.sx2   = 6'd0;
                    end else begin
                        r.st.third = 1'b0;
                        r.st.sx2   = val;
                    end
                    r.st.pos = 2'd3;
                end
                default: begin
                    if (cls == CLS_PAD) begin
                        if (pc != 2'd0) begin
                            r.ok = 1'b0;
                        end else begin
                            pc = 2'd1;
                        end
                    end
                    if (r.ok && s.third) begin
                        if (pc != 2'd1) begin
                            r.ok = 1'b0;
                        end else begin
                            pc = 2'd2;
                        end
                    end
                    if (r.ok) begin
                        r.cnt      = (pc == 2'd0) ? 2'd3 : ((pc == 2'd1) ? 2'd2 : 2'd1);
                        r.b0       = {s.sx0, s.sx1[5:4]};
                        r.b1       = {s.sx1[3:0], s.sx2[5:2]};
                        r.b2       = {s.sx2[1:0], c4};
                        r.st.pos   = 2'd0;
                        r.st.third = 1'b0;
                        r.st.pad   = pc;
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/b64u_stream_if.sv =====
// stream interfaces for text characters in and decoded bytes out
interface b64u_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface b64u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_char;
    logic       run_last;

    modport source (output valid, output out_byte, output bad_char, output run_last, input ready);
    modport sink   (input valid, input out_byte, input bad_char, input run_last, output ready);
endinterface

// ===== rtl/b64u_core.sv =====
// decoder state and single-pass group decode of one character
module b64u_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_in_char,
    input  logic                i_last_char,
    output b64u_pkg::t_res      o_res
);

    b64u_pkg::t_state r_st, n_st;
    logic             r_err, n_err;
    b64u_pkg::t_chr   chr;
    b64u_pkg::t_feed  f1, f2, f3, fin;
    logic             use2, use3, ok;

    always_comb begin
        chr  = b64u_pkg::classify(i_in_char);
        f1   = b64u_pkg::feed(r_st, chr.cls, chr.val);
        // short final group: fill missing positions with pads
        use2 = i_last_char && f1.ok && (f1.st.pos != 2'd0);
        f2   = b64u_pkg::feed(f1.st, b64u_pkg::CLS_PAD, 6'd0);
        use3 = use2 && f2.ok && (f2.st.pos != 2'd0);
        f3   = b64u_pkg::feed(f2.st, b64u_pkg::CLS_PAD, 6'd0);
        ok   = f1.ok && (!use2 || f2.ok) && (!use3 || f3.ok);
        fin  = use3 ? f3 : (use2 ? f2 : f1);

        o_res = '0;
        if (!r_err) begin
            if (!ok) begin
                o_res.cnt = 2'd1;
                o_res.bad = 1'b1;
            end else if (f1.cnt != 2'd0) begin
                o_res = '{cnt: f1.cnt, bad: 1'b0, b0: f1.b0, b1: f1.b1, b2: f1.b2};
            end else if (use2 && f2.cnt != 2'd0) begin
                o_res = '{cnt: f2.cnt, bad: 1'b0, b0: f2.b0, b1: f2.b1, b2: f2.b2};
            end else if (use3) begin
                o_res = '{cnt: f3.cnt, bad: 1'b0, b0: f3.b0, b1: f3.b1, b2: f3.b2};
            end
        end

        n_st  = r_st;
        n_err = r_err;
        if (i_step) begin
            if (i_last_char) begin
                n_st  = '0;
                n_err = 1'b0;
            end else if (!r_err) begin
                if (!ok) begin
                    n_err = 1'b1;
                end else begin
                    n_st = fin.st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_err <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_err <= n_err;
        end
    end

endmodule

// ===== rtl/b64u_obuf.sv =====
// result register holding up to three bytes of one group, drained one beat a cycle while the sink is ready
module b64u_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  b64u_pkg::t_res  i_res,
    output logic            o_free,
    b64u_byte_if.source     o_byte
);

    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_b0, r_b1, r_b2;
    logic       r_bad;
    logic       pop;

    assign o_byte.valid    = (r_cnt != 2'd0);
    assign o_byte.out_byte = r_b0;
    assign o_byte.bad_char = r_bad;
    assign o_byte.run_last = (r_cnt == 2'd1);
    assign pop             = o_byte.valid && o_byte.ready;
    assign o_free          = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_res.cnt;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b0  <= i_res.b0;
            r_b1  <= i_res.b1;
            r_b2  <= i_res.b2;
            r_bad <= i_res.bad;
        end else if (pop) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

    // no overwrite of undelivered bytes
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free) else $error("result register loaded while busy");

    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_res.cnt != 2'd0)) else $error("load of an empty result");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && r_bad) |-> o_byte.run_last) else $error("error beat not alone");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_cnt == 2'd1) && !i_load) |=> !o_byte.valid)
        else $error("stale beat after drain");

endmodule

// ===== rtl/base64url_decoder.sv =====
// an accepted character sits in the input register; its bytes then load the result register
// throughput: a character per cycle if the result register is free; a beat per ready cycle
// a group of four characters yields at most three beats, set by the three-byte result register
// reset: synchronous active-low, clears group state, error flag and pending beats
// after reset the block is ready at once
module base64url_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64u_char_if.sink   i_char,
    b64u_byte_if.source o_byte
);

    logic           r_in_v;
    logic [7:0]     r_in_char;
    logic           r_in_last;
    b64u_pkg::t_res res;
    logic           free;
    logic           advance;
    logic           take;

    assign advance      = r_in_v && ((res.cnt == 2'd0) || free);
    assign i_char.ready = !r_in_v || advance;
    assign take         = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (take) begin
            r_in_v <= 1'b1;
        end else if (advance) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_char <= i_char.in_char;
            r_in_last <= i_char.last_char;
        end
    end

    b64u_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_in_char   (r_in_char),
        .i_last_char (r_in_last),
        .o_res       (res)
    );

    b64u_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && (res.cnt != 2'd0)),
        .i_res   (res),
        .o_free  (free),
        .o_byte  (o_byte)
    );

endmodule

// ===== dv/tb_top.sv =====
// testbench for the base64url character-to-byte stream decoder
`timescale 1ns / 100ps

module tb_top;

    localparam int RAND_CHARS  = 330;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RX_HOLD_LEN = 300;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        int         gap;
    } t_text_item;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       fin;
    } t_byte_beat;

    logic i_clk;
    logic i_rst_n;

    b64u_char_if chr ();
    b64u_byte_if byt ();

    base64url_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chr),
        .o_byte  (byt)
    );

    t_text_item text_q[$];
    t_byte_beat want_bytes[$];
    logic [7:0] group_bytes[$];

    logic [5:0] sx0, sx1, sx2;
    logic [1:0] grp_pos;
    logic [1:0] pads;
    logic       err_seen;
    logic       third_pad;

    int  fails;
    int  cycles;
    int  rand_chars;
    int  chars_taken;
    bit  char_taken;
    bit  tx_calm;
    bit  rx_hold;
    int  gap_left;
    bit  gap_armed;
    int  stall_left;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return 8'("-");
        return 8'("_");
    endfunction

    function automatic b64u_pkg::t_cls char_class(input logic [7:0] ch,
                                                  output logic [5:0] v);
        v = '0;
        if (ch == b64u_pkg::CH_PAD) return b64u_pkg::CLS_PAD;
        if (ch >= "A" && ch <= "Z") begin
            v = 6'(ch - "A");
            return b64u_pkg::CLS_DATA;
        end
        if (ch >= "a" && ch <= "z") begin
            v = 6'(ch - "a" + 26);
            return b64u_pkg::CLS_DATA;
        end
        if (ch >= "0" && ch <= "9") begin
            v = 6'(ch - "0" + 52);
            return b64u_pkg::CLS_DATA;
        end
        if (ch == b64u_pkg::CH_DASH) begin
            v = 6'd62;
            return b64u_pkg::CLS_DATA;
        end
        if (ch == b64u_pkg::CH_UNDER) begin
            v = 6'd63;
            return b64u_pkg::CLS_DATA;
        end
        return b64u_pkg::CLS_BAD;
    endfunction

    function automatic void clear_group();
        sx0       = '0;
        sx1       = '0;
        sx2       = '0;
        grp_pos   = '0;
        pads      = '0;
        err_seen  = 1'b0;
        third_pad = 1'b0;
    endfunction

    // one sextet into the current group, bytes land in group_bytes
    function automatic bit take_sextet(input b64u_pkg::t_cls cls, input logic [5:0] v);
        logic [5:0] c4;
        if (cls == b64u_pkg::CLS_BAD) return 1'b0;
        case (grp_pos)
            2'd0: begin
                if (cls == b64u_pkg::CLS_PAD) return 1'b0;
                sx0     = v;
                grp_pos = 2'd1;
            end
            2'd1: begin
                if (cls == b64u_pkg::CLS_PAD) return 1'b0;
                sx1     = v;
                grp_pos = 2'd2;
            end
            2'd2: begin
                if (cls == b64u_pkg::CLS_PAD) begin
                    if (pads >= 2'd2) return 1'b0;
                    third_pad = 1'b1;
                    sx2       = '0;
                end else begin
                    third_pad = 1'b0;
                    sx2       = v;
                end
                grp_pos = 2'd3;
            end
            default: begin
                c4 = (cls == b64u_pkg::CLS_PAD) ? 6'd0 : v;
                if (cls == b64u_pkg::CLS_PAD) begin
                    if (pads != 2'd0) return 1'b0;
                    pads = 2'd1;
                end
                if (third_pad) begin
                    if (pads != 2'd1) return 1'b0;
                    pads = 2'd2;
                end
                group_bytes.push_back({sx0, sx1[5:4]});
                if (pads <= 2'd1) group_bytes.push_back({sx1[3:0], sx2[5:2]});
                if (pads == 2'd0) group_bytes.push_back({sx2[1:0], c4});
                grp_pos   = 2'd0;
                third_pad = 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic last);
        b64u_pkg::t_cls cls;
        logic [5:0]     v;
        bit             ok;
        if (err_seen) begin
            if (last) clear_group();
            return;
        end
        group_bytes.delete();
        cls = char_class(ch, v);
        ok  = take_sextet(cls, v);
        while (ok && last && grp_pos != 2'd0) ok = take_sextet(b64u_pkg::CLS_PAD, 6'd0);
        if (!ok) begin
            want_bytes.push_back('{data: 8'd0, bad: 1'b1, fin: 1'b1});
            err_seen = 1'b1;
        end else begin
            foreach (group_bytes[i])
                want_bytes.push_back('{data: group_bytes[i], bad: 1'b0,
                                       fin: (i == group_bytes.size() - 1)});
        end
        if (last) clear_group();
    endfunction

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic last);
        text_q.push_back('{ch: ch, last: last, gap: tx_calm ? 0 : rand_gap()});
    endtask

    task automatic queue_text(input string s, input bit end_msg);
        for (int i = 0; i < s.len(); i++) queue_char(s[i], end_msg && i == s.len() - 1);
    endtask

    task automatic gen_message();
        logic [7:0] txt[$];
        int kind, ngrp, tail, k;
        kind    = $urandom_range(0, 9);
        ngrp    = $urandom_range(0, 3);
        tail    = $urandom_range(0, 5);
        tx_calm = ($urandom_range(0, 3) == 0);
        if (ngrp == 0 && tail == 0) ngrp = 1;
        if (kind == 7) begin
            repeat ($urandom_range(1, 8)) begin
                k = $urandom_range(0, 3);
                if (k == 0) txt.push_back(b64u_pkg::CH_PAD);
                else if (k == 1) txt.push_back(b64_char($urandom_range(0, 63)));
                else txt.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            // padded group first, the pad count carries into later groups
            if (kind == 9) begin
                repeat ($urandom_range(2, 3)) txt.push_back(b64_char($urandom_range(0, 63)));
                while (txt.size() < 4) txt.push_back(b64u_pkg::CH_PAD);
            end
            repeat (ngrp * 4) txt.push_back(b64_char($urandom_range(0, 63)));
            case (tail)
                1: repeat (2) txt.push_back(b64_char($urandom_range(0, 63)));
                2: repeat (3) txt.push_back(b64_char($urandom_range(0, 63)));
                3: begin
                    repeat (2) txt.push_back(b64_char($urandom_range(0, 63)));
                    repeat (2) txt.push_back(b64u_pkg::CH_PAD);
                end
                4: begin
                    repeat (3) txt.push_back(b64_char($urandom_range(0, 63)));
                    txt.push_back(b64u_pkg::CH_PAD);
                end
                5: txt.push_back(b64_char($urandom_range(0, 63)));
                default: ;
            endcase
            if (kind == 8) begin
                k = $urandom_range(0, txt.size() - 1);
                txt[k] = $urandom_range(0, 1) ? b64u_pkg::CH_PAD
                                              : 8'($urandom_range(0, 255));
            end
        end
        foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
        rand_chars += txt.size();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sender
    always @(negedge i_clk) begin
        t_text_item it;
        if (!i_rst_n) begin
            chr.valid <= 1'b0;
        end else if (!(chr.valid && !char_taken)) begin
            if (text_q.size() != 0 && !gap_armed) begin
                gap_left  = text_q[0].gap;
                gap_armed = 1'b1;
            end
            if (text_q.size() != 0 && gap_left == 0) begin
                it            = text_q.pop_front();
                gap_armed     = 1'b0;
                chr.valid     <= 1'b1;
                chr.in_char   <= it.ch;
                chr.last_char <= it.last;
            end else begin
                chr.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rx_hold) begin
            byt.ready <= 1'b0;
        end else if (stall_left > 0) begin
            byt.ready <= 1'b0;
            stall_left--;
        end else begin
            byt.ready <= 1'b1;
            stall_left = ((cycles / 400) % 4 == 3) ? 0 : rand_gap();
        end
    end

    // long output hold-off while characters keep coming
    initial begin
        rx_hold = 1'b0;
        wait (chars_taken >= 180);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_LEN) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // predictor and checker
    always @(posedge i_clk) begin
        t_byte_beat w;
        if (!i_rst_n) begin
            char_taken <= 1'b0;
        end else begin
            char_taken <= chr.valid && chr.ready;
            if (chr.valid && chr.ready) begin
                decode_char(chr.in_char, chr.last_char);
                chars_taken++;
            end
            if (byt.valid && byt.ready) begin
                if (want_bytes.size() == 0) begin
                    note_mismatch($sformatf("beat with nothing expected: byte %02h bad %b last %b",
                                            byt.out_byte, byt.bad_char, byt.run_last));
                end else begin
                    w = want_bytes.pop_front();
                    if (byt.out_byte !== w.data)
                        note_mismatch($sformatf("out_byte %02h, want %02h", byt.out_byte, w.data));
                    if (byt.bad_char !== w.bad)
                        note_mismatch($sformatf("bad_char %b, want %b", byt.bad_char, w.bad));
                    if (byt.run_last !== w.fin)
                        note_mismatch($sformatf("run_last %b, want %b", byt.run_last, w.fin));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        chr.valid     = 1'b0;
        chr.in_char   = 8'd0;
        chr.last_char = 1'b0;
        byt.ready     = 1'b0;
        fails         = 0;
        cycles        = 0;
        rand_chars    = 0;
        chars_taken   = 0;
        char_taken    = 1'b0;
        gap_left      = 0;
        gap_armed     = 1'b0;
        stall_left    = 0;
        tx_calm       = 1'b0;
        clear_group();

        // directed: alphabet extremes, short groups, pads, errors
        queue_text("A_-z", 1'b0);
        queue_text("Za9", 1'b1);
        queue_text("0y", 1'b1);
        queue_char(8'hFF, 1'b0);
        queue_char("A", 1'b1);
        queue_char("z", 1'b1);
        queue_char(b64u_pkg::CH_PAD, 1'b1);
        queue_text("AAA", 1'b0);
        queue_char(b64u_pkg::CH_PAD, 1'b0);
        queue_text("B9_-", 1'b1);
        queue_text("AA", 1'b0);
        queue_char(b64u_pkg::CH_PAD, 1'b0);
        queue_char("B", 1'b1);

        while (rand_chars < RAND_CHARS) gen_message();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || chr.valid) @(posedge i_clk);
        while (want_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
